### rtl/assert_macros.svh
// Assertion macros used by the checker file hslc_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, reset-qualified.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/hslc_pkg.sv
// Types and constants for the HSL to RGB converter pipeline.
// Depends on nothing.
package hslc_pkg;

    localparam int HUE_W   = 9;
    localparam int CH_W    = 8;
    localparam int SECT_W  = 3;
    localparam int SPAN_W  = 6;
    localparam int MOD_W   = 7;
    localparam int AREA_W  = 16;
    localparam int VAL_W   = 23;
    localparam int SUM_W   = 24;
    localparam int SCL_W   = 20;
    localparam int RCP_W   = 21;
    localparam int PROD_W  = SCL_W + RCP_W;
    localparam int RCP_SHIFT = 32;
    localparam int QUO_W   = PROD_W - RCP_SHIFT;
    localparam int DEN_SHIFT = 3;

    localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 9'd240;
    localparam logic [HUE_W-1:0] HUE_THIRD      = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SECTOR     = 9'd60;
    localparam logic [MOD_W-1:0] MOD_SECTOR     = 7'd60;
    localparam logic [MOD_W-1:0] MOD_THIRD      = 7'd120;

    // 30600 = 8 * 3825; quotient by 3825 via ceil(2^32 / 3825)
    localparam logic [14:0]      LIGHT_SCALE = 15'd30600;
    localparam logic [RCP_W-1:0] RCP_K       = 21'd1122868;
    localparam logic [QUO_W-1:0] QUO_MAX     = 9'd255;

    localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANES      = 3;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [SPAN_W-1:0] span;
        logic [AREA_W-1:0] area;
        logic [CH_W-1:0]   light;
    } prod_t;

    typedef logic [LANES-1:0][SCL_W-1:0] scaled_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

endpackage

### rtl/hslc_front.sv
// Front stages: hue wrap, sector, hue span, lightness factor, then area = a * s.
// Depends on hslc_pkg.
module hslc_front
    import hslc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CH_W-1:0]   saturation,
    input  logic [CH_W-1:0]   lightness,
    output logic              out_valid,
    input  logic              out_ready,
    output prod_t             out_data
);

    logic              v1_reg;
    logic              v2_reg;
    logic              rdy1;
    logic              rdy2;

    logic [SECT_W-1:0] sector_reg;
    logic [SECT_W-1:0] sector_next;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] span_next;
    logic [CH_W-1:0]   fac_reg;
    logic [CH_W-1:0]   fac_next;
    logic [CH_W-1:0]   sat_reg;
    logic [CH_W-1:0]   light_reg;
    prod_t             out_reg;
    prod_t             out_next;

    logic [HUE_W-1:0]  h_w;
    logic [MOD_W-1:0]  h_mod;
    logic [HUE_W-1:0]  fac_wide;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        h_w = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;

        if (h_w >= HUE_TWO_THIRDS)
        begin
            h_mod = MOD_W'(h_w - HUE_TWO_THIRDS);
        end
        else if (h_w >= HUE_THIRD)
        begin
            h_mod = MOD_W'(h_w - HUE_THIRD);
        end
        else
        begin
            h_mod = MOD_W'(h_w);
        end

        // triangle 0..60..0 over each 120-degree period
        span_next = (h_mod >= MOD_SECTOR) ? SPAN_W'(MOD_THIRD - h_mod) : SPAN_W'(h_mod);

        // boundaries belong to the lower sector
        if (h_w <= HUE_SECTOR)
        begin
            sector_next = SECT_RED_YEL;
        end
        else if (h_w <= HUE_THIRD)
        begin
            sector_next = SECT_YEL_GRN;
        end
        else if (h_w <= HUE_THIRD + HUE_SECTOR)
        begin
            sector_next = SECT_GRN_CYN;
        end
        else if (h_w <= HUE_TWO_THIRDS)
        begin
            sector_next = SECT_CYN_BLU;
        end
        else if (h_w <= HUE_TWO_THIRDS + HUE_SECTOR)
        begin
            sector_next = SECT_BLU_MAG;
        end
        else
        begin
            sector_next = SECT_MAG_RED;
        end

        // 255 - |2l - 255|
        fac_wide = 9'd510 - {lightness, 1'b0};
        fac_next = lightness[CH_W-1] ? fac_wide[CH_W-1:0] : {lightness[CH_W-2:0], 1'b0};
    end

    always_comb
    begin
        out_next.sector = sector_reg;
        out_next.span   = span_reg;
        out_next.area   = fac_reg * sat_reg;
        out_next.light  = light_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            sector_reg <= sector_next;
            span_reg   <= span_next;
            fac_reg    <= fac_next;
            sat_reg    <= saturation;
            light_reg  <= lightness;
        end
        if (rdy2)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

### rtl/hslc_mix.sv
// Mix stages: chroma, secondary and offset numerators, then per-channel sums over 30600.
// Depends on hslc_pkg.
module hslc_mix
    import hslc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  prod_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output scaled_t out_data
);

    logic                    v3_reg;
    logic                    v4_reg;
    logic                    rdy3;
    logic                    rdy4;

    logic [SECT_W-1:0]       sector_reg;
    logic [VAL_W-1:0]        cv_reg;
    logic [VAL_W-1:0]        cv_next;
    logic [VAL_W-1:0]        xv_reg;
    logic [VAL_W-1:0]        xv_next;
    logic signed [SUM_W-1:0] base_reg;
    logic signed [SUM_W-1:0] base_next;
    scaled_t                 out_reg;
    scaled_t                 out_next;

    logic [VAL_W-2:0]        area_span;
    logic [VAL_W-2:0]        area_half;
    logic [VAL_W-1:0]        light_num;
    logic [LANES-1:0][VAL_W-1:0]    v_sel;
    logic signed [SUM_W-1:0] num [LANES];

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_comb
    begin
        cv_next   = {in_data.area, 7'b0} - {4'b0, in_data.area, 3'b0};
        area_half = {in_data.area, 6'b0} - {4'b0, in_data.area, 2'b0};
        area_span = (VAL_W-1)'(in_data.area * in_data.span);
        xv_next   = {area_span, 1'b0};
        light_num = VAL_W'(in_data.light * LIGHT_SCALE);
        base_next = $signed({1'b0, light_num}) - $signed({2'b0, area_half});
    end

    always_comb
    begin
        case (sector_reg)
            SECT_RED_YEL: v_sel = {VAL_W'(0), xv_reg, cv_reg};
            SECT_YEL_GRN: v_sel = {VAL_W'(0), cv_reg, xv_reg};
            SECT_GRN_CYN: v_sel = {xv_reg, cv_reg, VAL_W'(0)};
            SECT_CYN_BLU: v_sel = {cv_reg, xv_reg, VAL_W'(0)};
            SECT_BLU_MAG: v_sel = {cv_reg, VAL_W'(0), xv_reg};
            default:      v_sel = {xv_reg, VAL_W'(0), cv_reg};
        endcase

        for (int i = 0; i < LANES; i++)
        begin
            num[i]      = $signed({1'b0, v_sel[i]}) + base_reg;
            out_next[i] = num[i][SUM_W-1] ? SCL_W'(0) : num[i][SUM_W-2:DEN_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sector_reg <= in_data.sector;
            cv_reg     <= cv_next;
            xv_reg     <= xv_next;
            base_reg   <= base_next;
        end
        if (rdy4)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

### rtl/hslc_div.sv
// Divide stages: per-channel quotient by 3825 via reciprocal multiply, then clamp.
// Depends on hslc_pkg.
module hslc_div
    import hslc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  scaled_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output rgb_t    out_data
);

    logic                         v5_reg;
    logic                         v6_reg;
    logic                         rdy5;
    logic                         rdy6;

    logic [LANES-1:0][QUO_W-1:0]  quo_reg;
    logic [LANES-1:0][QUO_W-1:0]  quo_next;
    logic [LANES-1:0][CH_W-1:0]   chan_next;
    rgb_t                         out_reg;
    rgb_t                         out_next;
    logic [PROD_W-1:0]            prod [LANES];

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i]      = in_data[i] * RCP_K;
            quo_next[i]  = prod[i][PROD_W-1:RCP_SHIFT];
            chan_next[i] = (quo_reg[i] > QUO_MAX) ? CH_W'(QUO_MAX) : quo_reg[i][CH_W-1:0];
        end
        out_next.red   = chan_next[LANE_RED];
        out_next.green = chan_next[LANE_GREEN];
        out_next.blue  = chan_next[LANE_BLUE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy5)
            begin
                v5_reg <= in_valid;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            quo_reg <= quo_next;
        end
        if (rdy6)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_reg;

endmodule

### rtl/hsl_to_rgb_converter_unit.sv
// Pipeline: 6 register stages; an accepted word passes through each in turn and is shown
// on the output by the last, where it leaves once m_axis_tready is high.
// Throughput: one word per clock unless the output stalls; each of the 6 stages holds one
// word with its own valid bit and takes a new word when it is empty or its word moves on.
// Reset: rst_n (async, active low) clears every valid bit; datapath registers are not reset.
// Top level of the HSL to RGB converter; depends on hslc_pkg, hslc_front, hslc_mix, hslc_div.
module hsl_to_rgb_converter_unit
    import hslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[8:0], saturation[16:9], lightness[24:17], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic    front_valid;
    logic    front_ready;
    prod_t   front_data;
    logic    mix_valid;
    logic    mix_ready;
    scaled_t mix_data;
    rgb_t    rgb;

    hslc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[8:0]),
        .saturation (s_axis_tdata[16:9]),
        .lightness  (s_axis_tdata[24:17]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    hslc_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    hslc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (rgb)
    );

    assign m_axis_tdata = rgb;

endmodule

### rtl/hslc_checker.sv
// Port-level checker for the HSL to RGB converter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hslc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled output word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // input backpressure only when the whole pipe is full behind a stalled output
    `ASSERT_IMPL(a_full_only, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // zero saturation gives gray at the lightness level once the word has passed every stage unstalled
    `ASSERT_NEXT(a_gray_latency, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tdata[16:9] == 8'd0
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready,
        m_axis_tvalid && m_axis_tdata[7:0] == $past(s_axis_tdata[24:17], 6)
            && m_axis_tdata[15:8] == $past(s_axis_tdata[24:17], 6)
            && m_axis_tdata[23:16] == $past(s_axis_tdata[24:17], 6))

    // full lightness is white
    `ASSERT_NEXT(a_white_out, clk, rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tdata[24:17] == 8'hff
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready,
        m_axis_tvalid && m_axis_tdata == 24'hffffff)

endmodule

bind hsl_to_rgb_converter_unit hslc_checker u_checker (.*);

### sim/tb_top.sv
// Testbench for hsl_to_rgb_converter_unit: drives HSL words, predicts RGB words, checks each one.
// Depends on hslc_pkg and the converter RTL. Runs standalone, no files or arguments.
module tb_top;
    import hslc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    rgb_t expected_rgb [$];
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   rx_hold_len = 0;
    int   colors_sent = 0;
    int   colors_checked = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    hsl_to_rgb_converter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue_in,
                                         input logic [CH_W-1:0] sat_in,
                                         input logic [CH_W-1:0] light_in);
        longint hue;
        longint light_dev;
        longint area;
        longint fold;
        longint chroma;
        longint second;
        longint base;
        longint num;
        longint lane_val [LANES];
        logic [SECT_W-1:0] sector;
        logic [LANES-1:0][CH_W-1:0] lanes;
        hue = longint'(hue_in);
        if (hue >= HUE_FULL)
            hue -= HUE_FULL;
        light_dev = 2 * longint'(light_in) - 255;
        if (light_dev < 0)
            light_dev = -light_dev;
        area = 255 - light_dev;
        fold = hue % HUE_THIRD - HUE_SECTOR;
        if (fold < 0)
            fold = -fold;
        chroma = area * sat_in * 120;
        second = area * sat_in * (HUE_SECTOR - fold) * 2;
        base   = longint'(light_in) * LIGHT_SCALE - area * sat_in * 60;
        // sector edges belong to the lower sector
        sector = (hue == 0) ? SECT_RED_YEL : SECT_W'((hue - 1) / HUE_SECTOR);
        case (sector)
            SECT_RED_YEL: lane_val = '{chroma, second, 0};
            SECT_YEL_GRN: lane_val = '{second, chroma, 0};
            SECT_GRN_CYN: lane_val = '{0, chroma, second};
            SECT_CYN_BLU: lane_val = '{0, second, chroma};
            SECT_BLU_MAG: lane_val = '{second, 0, chroma};
            default:      lane_val = '{chroma, 0, second};
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            num = lane_val[i] + base;
            if (num < 0)
                num = 0;
            num = num / LIGHT_SCALE;
            if (num > QUO_MAX)
                num = QUO_MAX;
            lanes[i] = num[CH_W-1:0];
        end
        return rgb_t'(lanes);
    endfunction

    // one input word; returns right after the edge that accepted it, or after a random idle gap behind it
    task automatic send_color(input logic [HUE_W-1:0] hue,
                              input logic [CH_W-1:0] sat,
                              input logic [CH_W-1:0] light);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, light, sat, hue};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_rgb.push_back(predict_rgb(hue, sat, light));
        colors_sent++;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return CH_W'($urandom_range(0, 255));
    endfunction

    task automatic test_sector_boundaries();
        int unsigned corners [25][3] = '{
            '{0, 255, 128}, '{1, 255, 128}, '{59, 255, 128}, '{60, 255, 128},
            '{61, 255, 128}, '{119, 200, 100}, '{120, 255, 128}, '{121, 255, 128},
            '{180, 255, 128}, '{239, 180, 90}, '{240, 255, 128}, '{241, 255, 128},
            '{299, 255, 128}, '{300, 255, 128}, '{301, 77, 200}, '{359, 255, 128},
            '{360, 255, 128}, '{511, 255, 255}, '{30, 0, 128}, '{200, 255, 0},
            '{200, 255, 255}, '{90, 255, 127}, '{90, 255, 128}, '{0, 0, 0},
            '{420, 128, 64}
        };
        tx_idle_pct = 0;
        foreach (corners[i])
            send_color(HUE_W'(corners[i][0]), CH_W'(corners[i][1]), CH_W'(corners[i][2]));
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        logic [HUE_W-1:0] hue;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        repeat (count)
        begin
            // mostly legal hues, some that wrap
            hue = ($urandom_range(0, 9) == 0) ? HUE_W'($urandom_range(360, 511))
                                              : HUE_W'($urandom_range(0, 359));
            send_color(hue, pick_channel(), pick_channel());
        end
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        rx_hold_len <= 300;
        repeat (40)
            send_color(HUE_W'($urandom_range(0, 511)), pick_channel(), pick_channel());
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_len != 0)
            rx_hold_len <= rx_hold_len - 1;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= (rx_hold_len == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        string lane_name [LANES] = '{"red", "green", "blue"};
        logic [LANES-1:0][CH_W-1:0] want;
        logic [LANES-1:0][CH_W-1:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[LANES*CH_W-1:0];
            if (expected_rgb.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_rgb.pop_front();
                colors_checked++;
                for (int i = 0; i < LANES; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: %s mismatch, expected %0d, actual %0d",
                                 $time, lane_name[i], want[i], got[i]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_rgb.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sector_boundaries();
        test_random_traffic(620, 38, 54);
        test_random_traffic(620, 54, 38);
        test_random_traffic(620, 0, 0);
        test_output_stall();
        s_axis_tvalid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("Sent %0d HSL words (sector edges, hue wrap, gray/black/white, random),",
                 colors_sent);
        $display("checked %0d RGB words under mixed idling and a long output stall.",
                 colors_checked);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hslc_pkg.sv
rtl/hslc_front.sv
rtl/hslc_mix.sv
rtl/hslc_div.sv
rtl/hsl_to_rgb_converter_unit.sv
rtl/hslc_checker.sv
sim/tb_top.sv
